FILE: rtl/core/mlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_pkg: shared types and constants of the mac learning table
// defaults, request codes and helper functions
// ----------------------------------------------------------------------------
package mlt_pkg;

  localparam int unsigned BucketsDefault = 256;
  localparam int unsigned WaysDefault    = 4;
  localparam int unsigned PortsDefault   = 16;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned PortW  = 4;
  localparam int unsigned StampW = 16;
  localparam int unsigned CountW = 11;
  localparam int unsigned ReqW   = 2;

  localparam logic [StampW-1:0] TimeoutReset = 16'd30;
  localparam logic [CountW-1:0] CountMax     = 11'd2047;

  typedef enum logic [ReqW-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_LEARN  = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // one way of a bucket as held in the entry memory
  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  addr;
    logic [PortW-1:0]  port;
    logic [StampW-1:0] stamp;
  } entry_t;

  localparam int unsigned EntryW = 1 + AddrW + PortW + StampW;

  // xor of the six address bytes
  function automatic logic [7:0] hash_bytes(input logic [AddrW-1:0] a);
    logic [7:0] h;
    h = 8'd0;
    for (int b = 0; b < 6; b++) begin
      h = h ^ a[8*b +: 8];
    end
    return h;
  endfunction

endpackage

FILE: rtl/core/mlt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_if: valid/ready channel interfaces
// request, result and configuration channels
// ----------------------------------------------------------------------------
interface mlt_req_if;
  logic                       valid;
  logic                       ready;
  logic [mlt_pkg::ReqW-1:0]   req_type;
  logic [mlt_pkg::AddrW-1:0]  mac_address;
  logic [mlt_pkg::PortW-1:0]  port_number;
  modport source (output valid, req_type, mac_address, port_number, input ready);
  modport sink (input valid, req_type, mac_address, port_number, output ready);
endinterface

interface mlt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [mlt_pkg::PortW-1:0]   found_port;
  logic                        learn_dropped;
  logic [mlt_pkg::CountW-1:0]  removed_count;
  modport source (output valid, hit, found_port, learn_dropped, removed_count,
                  input ready);
  modport sink (input valid, hit, found_port, learn_dropped, removed_count,
                output ready);
endinterface

interface mlt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mlt_pkg::StampW-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/mlt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_ram: generic single-port synchronous ram
// one read or write per cycle, registered read data
// ----------------------------------------------------------------------------
module mlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/core/mlt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_ctrl: request sequencer of the mac learning table
// bucket read-modify-write one way per cycle, and the aging sweep
// ----------------------------------------------------------------------------
module mlt_ctrl #(
  parameter int unsigned Buckets = mlt_pkg::BucketsDefault,
  parameter int unsigned Ways    = mlt_pkg::WaysDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  mlt_req_if.sink   req,
  mlt_rsp_if.source rsp,
  mlt_cfg_if.sink   cfg
);

  localparam int unsigned Entries = Buckets * Ways;
  localparam int unsigned EIdxW   = $clog2(Entries);
  localparam int unsigned BktW    = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned WayW    = (Ways > 1) ? $clog2(Ways) : 1;
  localparam logic [EIdxW:0] EntriesLast = (EIdxW+1)'(Entries - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;
  localparam logic [2:0] S_AGE   = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;

  logic [2:0] state_q, state_d;

  logic [mlt_pkg::StampW-1:0] timeout_q, now_q;

  // request copy
  logic [mlt_pkg::ReqW-1:0]   rtype_q;
  logic [mlt_pkg::AddrW-1:0]  raddr_q;
  logic [mlt_pkg::PortW-1:0]  rport_q;
  logic [BktW-1:0]            bucket_q;

  // way walk
  logic [WayW:0]  way_q;        // ways issued
  logic           rd_pend_q;    // a read is in flight
  logic [WayW-1:0] rd_way_q;
  logic           found_q, free_q;
  logic [WayW-1:0] hit_way_q, free_way_q;
  logic [mlt_pkg::PortW-1:0] hport_q;

  // sweep and clear walk
  logic [EIdxW:0]  sidx_q;
  logic [mlt_pkg::CountW-1:0] cnt_q;

  // result register
  logic rsp_valid_q, rhit_q, rdrop_q;
  logic [mlt_pkg::PortW-1:0]  rfport_q;
  logic [mlt_pkg::CountW-1:0] rcnt_q;

  // ram port
  logic                        we;
  logic [EIdxW-1:0]            addr;
  mlt_pkg::entry_t             wdata, rdata;

  mlt_ram #(.Width(mlt_pkg::EntryW), .Depth(Entries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  function automatic logic [EIdxW-1:0] eidx(input logic [BktW-1:0] b,
                                            input logic [WayW-1:0] w);
    return EIdxW'(b * Ways + w);
  endfunction

  // hash byte to bucket as a constant table
  function automatic logic [BktW-1:0] bucket_of(input logic [7:0] h);
    logic [BktW-1:0] b;
    b = '0;
    for (int i = 0; i < 256; i++) begin
      if (h == 8'(i)) b = BktW'(i % Buckets);
    end
    return b;
  endfunction

  logic             rd_match;
  logic [mlt_pkg::StampW-1:0] age;
  logic             expire;

  assign rd_match = rdata.valid && (rdata.addr == raddr_q);
  assign age      = now_q - rdata.stamp;
  assign expire   = rdata.valid && (age >= timeout_q);

  assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign cfg.ready = 1'b1;

  assign rsp.valid         = rsp_valid_q;
  assign rsp.hit           = rhit_q;
  assign rsp.found_port    = rfport_q;
  assign rsp.learn_dropped = rdrop_q;
  assign rsp.removed_count = rcnt_q;

  logic scan_done;
  assign scan_done = (way_q == (WayW+1)'(Ways)) && !rd_pend_q;

  // ram address and write data
  always_comb begin
    we    = 1'b0;
    addr  = '0;
    wdata = '{valid: 1'b1, addr: raddr_q, port: rport_q, stamp: now_q};
    unique case (state_q)
      S_SCAN:  addr = eidx(bucket_q, way_q[WayW-1:0]);
      S_WRITE: begin
        we = found_q || (free_q && rtype_q == mlt_pkg::REQ_LEARN);
        if (found_q) begin
          addr  = eidx(bucket_q, hit_way_q);
          wdata = '{valid: 1'b1, addr: raddr_q, port: hport_q, stamp: now_q};
        end else begin
          addr = eidx(bucket_q, free_way_q);
        end
      end
      S_SWEEP: addr = sidx_q[EIdxW-1:0];
      S_AGE: begin
        // expired entry written back with its valid bit cleared
        we    = expire;
        addr  = sidx_q[EIdxW-1:0];
        wdata = '{valid: 1'b0, addr: rdata.addr, port: rdata.port, stamp: rdata.stamp};
      end
      S_CLEAR: begin
        we    = 1'b1;
        addr  = sidx_q[EIdxW-1:0];
        wdata = '{valid: 1'b0, addr: '0, port: '0, stamp: '0};
      end
      default: addr = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          if (req.req_type == mlt_pkg::REQ_LOOKUP || req.req_type == mlt_pkg::REQ_LEARN)
            state_d = S_SCAN;
          else if (req.req_type == mlt_pkg::REQ_TICK) state_d = S_SWEEP;
          else state_d = S_RESP;
        end
      end
      S_SCAN:  if (scan_done) state_d = S_WRITE;
      S_WRITE: state_d = S_RESP;
      S_SWEEP: state_d = S_AGE;
      S_AGE:   state_d = (sidx_q == EntriesLast) ? S_RESP : S_SWEEP;
      S_CLEAR: if (sidx_q == EntriesLast) state_d = S_IDLE;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      timeout_q   <= mlt_pkg::TimeoutReset;
      now_q       <= '0;
      rsp_valid_q <= 1'b0;
      way_q       <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      sidx_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg.valid) timeout_q <= cfg.data;
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          way_q     <= '0;
          rd_pend_q <= 1'b0;
          found_q   <= 1'b0;
          free_q    <= 1'b0;
          sidx_q    <= '0;
          cnt_q     <= '0;
          if (req.valid && req.ready && req.req_type == mlt_pkg::REQ_TICK) begin
            now_q <= now_q + 1'b1;
          end
        end
        S_SCAN: begin
          rd_pend_q <= (way_q != (WayW+1)'(Ways));
          rd_way_q  <= way_q[WayW-1:0];
          if (way_q != (WayW+1)'(Ways)) way_q <= way_q + 1'b1;
          if (rd_pend_q) begin
            if (rd_match && !found_q) begin
              found_q   <= 1'b1;
              hit_way_q <= rd_way_q;
              hport_q   <= rdata.port;
            end
            if (!rdata.valid && !free_q) begin
              free_q     <= 1'b1;
              free_way_q <= rd_way_q;
            end
          end
        end
        S_AGE: begin
          if (expire && cnt_q != mlt_pkg::CountMax) cnt_q <= cnt_q + 1'b1;
          if (sidx_q != EntriesLast) sidx_q <= sidx_q + 1'b1;
        end
        S_CLEAR: begin
          if (sidx_q != EntriesLast) sidx_q <= sidx_q + 1'b1;
        end
        S_RESP: rsp_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req.valid && req.ready) begin
      rtype_q  <= req.req_type;
      raddr_q  <= req.mac_address;
      rport_q  <= req.port_number;
      bucket_q <= bucket_of(mlt_pkg::hash_bytes(req.mac_address));
    end
    if (state_q == S_RESP) begin
      rhit_q   <= found_q;
      rfport_q <= found_q ? hport_q : '0;
      rdrop_q  <= !found_q && !free_q && rtype_q == mlt_pkg::REQ_LEARN;
      rcnt_q   <= cnt_q;
    end
  end

  // a lookup never writes a new entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && rtype_q == mlt_pkg::REQ_LOOKUP) |-> (!we || found_q))
    else $error("lookup inserted an entry");
  // one result per request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |-> !rsp_valid_q)
    else $error("result overwritten");
  // no request taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !req.ready)
    else $error("request accepted with result pending");
  // a tick advances time by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && $past(state_q) == S_IDLE) |-> now_q == $past(now_q) + 1'b1)
    else $error("time step wrong");

endmodule

FILE: rtl/core/mac_learning_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_learning_table_core: switch mac learning table with aging
// set-associative bucket table in one ram, lookup, learn and tick sweep
// ----------------------------------------------------------------------------
// lookup or learn: the single ram port reads the bucket one way a cycle,
//   then writes back
// tick: a read and a write-back slot per entry
// unused request code: no state change
// one item at a time; next item accepted after the result is taken
// reset: time cleared, timeout back to 30, then a pass over all BUCKETS*WAYS
//   entries clears every valid bit in the ram with the input held not ready
module mac_learning_table_core #(
  parameter int unsigned BUCKETS = mlt_pkg::BucketsDefault,
  parameter int unsigned WAYS    = mlt_pkg::WaysDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  mlt_req_if.sink   req,
  mlt_rsp_if.source rsp,
  mlt_cfg_if.sink   cfg
);

  // sequencer with the entry ram inside
  mlt_ctrl #(.Buckets(BUCKETS), .Ways(WAYS)) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req),
    .rsp   (rsp),
    .cfg   (cfg)
  );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the mac learning table core
// drives lookup, learn, tick and unused-code items and config writes with random idling on both channels,
// predicts each result from a local copy of the table and checks it
// ----------------------------------------------------------------------------
module tb_top;
  import mlt_pkg::*;

  localparam int unsigned NB = BucketsDefault;
  localparam int unsigned NW = WaysDefault;
  localparam int unsigned NE = NB * NW;
  localparam int unsigned WDOG_LIMIT = 20000;

  typedef struct packed {
    logic              is_cfg;
    logic [StampW-1:0] cfg_data;
    req_e              kind;
    logic [AddrW-1:0]  addr;
    logic [PortW-1:0]  port;
  } op_t;

  typedef struct packed {
    logic              hit;
    logic [PortW-1:0]  port;
    logic              dropped;
    logic [CountW-1:0] removed;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mlt_req_if req ();
  mlt_rsp_if rsp ();
  mlt_cfg_if cfg ();

  mac_learning_table_core #(.BUCKETS(NB), .WAYS(NW)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .rsp   (rsp.source),
    .cfg   (cfg.sink)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the table
  logic              tbl_valid [NE];
  logic [AddrW-1:0]  tbl_addr  [NE];
  logic [PortW-1:0]  tbl_port  [NE];
  logic [StampW-1:0] tbl_stamp [NE];
  logic [StampW-1:0] now_ticks;
  logic [StampW-1:0] aging_limit;

  op_t  pending_ops[$];
  res_t expected_res[$];
  int   err_count = 0;
  bit   quiet_tail = 0;
  int   wdog = 0;

  // random addresses kept for reuse, so later requests can hit
  logic [AddrW-1:0] known_addrs[$];

  function automatic int bucket_base(logic [AddrW-1:0] a);
    logic [7:0] h;
    h = '0;
    for (int b = 0; b < 6; b++) h ^= a[8*b +: 8];
    return (int'(h) % NB) * NW;
  endfunction

  // table update and expected result for one accepted request
  function automatic res_t table_step(op_t op);
    res_t r;
    int   base;
    int   found;
    int   n;
    r = '0;
    found = -1;
    if (op.kind == REQ_LOOKUP || op.kind == REQ_LEARN) begin
      base = bucket_base(op.addr);
      for (int w = 0; w < NW; w++)
        if (found < 0 && tbl_valid[base+w] && tbl_addr[base+w] == op.addr) found = base + w;
      if (found >= 0) begin
        r.hit = 1'b1;
        r.port = tbl_port[found];
        tbl_stamp[found] = now_ticks;
      end else if (op.kind == REQ_LEARN) begin
        r.dropped = 1'b1;
        for (int w = 0; w < NW; w++)
          if (r.dropped && !tbl_valid[base+w]) begin
            tbl_valid[base+w] = 1'b1;
            tbl_addr[base+w] = op.addr;
            tbl_port[base+w] = op.port;
            tbl_stamp[base+w] = now_ticks;
            r.dropped = 1'b0;
          end
      end
    end else if (op.kind == REQ_TICK) begin
      n = 0;
      now_ticks = now_ticks + 1'b1;
      for (int i = 0; i < NE; i++)
        if (tbl_valid[i] && StampW'(now_ticks - tbl_stamp[i]) >= aging_limit) begin
          tbl_valid[i] = 1'b0;
          if (n < int'(CountMax)) n++;
        end
      r.removed = CountW'(n);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // ---------------------------------------------------------------- driver
  // request items and config writes come from one queue; a config write
  // waits until every expected result has come back plus a settle gap
  int unsigned gap_left = 0;
  int unsigned settle = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.req_type <= REQ_LOOKUP;
      req.mac_address <= '0;
      req.port_number <= '0;
      cfg.valid <= 1'b0;
      cfg.data <= '0;
    end else begin
      op_t op;
      bit req_busy;
      bit cfg_busy;
      req_busy = req.valid && !req.ready;
      cfg_busy = cfg.valid && !cfg.ready;
      if (req.valid && req.ready) expected_res.push_back(table_step(pending_ops.pop_front()));
      if (cfg.valid && cfg.ready) begin
        aging_limit = pending_ops.pop_front().cfg_data;
      end
      if (expected_res.size() != 0) settle = 0;
      else if (settle < NE + 16) settle++;
      if (!req_busy && !cfg_busy) begin
        logic nv_req;
        logic nv_cfg;
        nv_req = 1'b0;
        nv_cfg = 1'b0;
        if (pending_ops.size() > 0 && !(req.valid && !req.ready) &&
            !(cfg.valid && cfg.ready) && !(req.valid && req.ready)) begin
          op = pending_ops[0];
          if (gap_left > 0) begin
            gap_left--;
          end else if (op.is_cfg) begin
            // hold the write until the block has drained
            if (expected_res.size() == 0 && settle >= NE + 8) begin
              nv_cfg = 1'b1;
              cfg.data <= op.cfg_data;
            end
          end else begin
            nv_req = 1'b1;
            req.req_type <= op.kind;
            req.mac_address <= op.addr;
            req.port_number <= op.port;
            if (!quiet_tail && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 6);
          end
        end
        req.valid <= nv_req;
        cfg.valid <= nv_cfg;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      res_t w;
      if (rsp.valid && rsp.ready) begin
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected result", 64'({rsp.hit, rsp.found_port}), 64'(0));
        end else begin
          w = expected_res.pop_front();
          if (rsp.hit !== w.hit) report_mismatch("hit", 64'(rsp.hit), 64'(w.hit));
          if (rsp.found_port !== w.port)
            report_mismatch("found_port", 64'(rsp.found_port), 64'(w.port));
          if (rsp.learn_dropped !== w.dropped)
            report_mismatch("learn_dropped", 64'(rsp.learn_dropped), 64'(w.dropped));
          if (rsp.removed_count !== w.removed)
            report_mismatch("removed_count", 64'(rsp.removed_count), 64'(w.removed));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready) ||
          pending_ops.size() == 0 && expected_res.size() == 0)
        wdog <= 0;
      else
        wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [AddrW-1:0] rand_addr();
    return AddrW'({$urandom, $urandom});
  endfunction

  // address chosen to land in a given bucket (xor of bytes equals bkt)
  function automatic logic [AddrW-1:0] addr_in_bucket(logic [7:0] bkt);
    logic [AddrW-1:0] a;
    logic [7:0] h;
    a = rand_addr();
    h = '0;
    for (int b = 1; b < 6; b++) h ^= a[8*b +: 8];
    a[7:0] = h ^ bkt;
    return a;
  endfunction

  task automatic push_req(req_e k, logic [AddrW-1:0] a, logic [PortW-1:0] p);
    op_t o;
    o = '0;
    o.kind = k;
    o.addr = a;
    o.port = p;
    pending_ops.push_back(o);
  endtask

  task automatic push_cfg(logic [StampW-1:0] d);
    op_t o;
    o = '0;
    o.is_cfg = 1'b1;
    o.cfg_data = d;
    pending_ops.push_back(o);
  endtask

  // one random phase: mostly learns and lookups of known addresses,
  // ticks now and then, a few unused codes, some crowded buckets
  task automatic random_phase(int count, int tick_pct);
    logic [AddrW-1:0] a;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (known_addrs.size() == 0 || $urandom_range(0, 2) == 0) begin
        a = ($urandom_range(0, 3) == 0) ? addr_in_bucket(8'($urandom_range(0, 3)))
                                        : rand_addr();
        if ($urandom_range(0, 1) == 0) known_addrs.push_back(a);
      end else begin
        a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
      end
      if (sel < tick_pct) push_req(REQ_TICK, rand_addr(), 4'($urandom));
      else if (sel < tick_pct + 2) push_req(REQ_NONE, rand_addr(), 4'($urandom));
      else if (sel < 55) push_req(REQ_LEARN, a, 4'($urandom));
      else push_req(REQ_LOOKUP, a, 4'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NE; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i] = '0;
      tbl_port[i] = '0;
      tbl_stamp[i] = '0;
    end
    now_ticks = '0;
    aging_limit = TimeoutReset;

    // directed: extremes, every request code, full bucket, aging
    push_req(REQ_LOOKUP, '0, '0);
    push_req(REQ_LEARN, '0, 4'hF);
    push_req(REQ_LOOKUP, '0, '0);
    push_req(REQ_LEARN, '1, 4'h0);
    push_req(REQ_LEARN, '1, 4'h7);              // present: port kept
    push_req(REQ_LOOKUP, '1, '0);
    push_req(REQ_NONE, '1, 4'hF);               // unused code
    for (int w = 0; w < NW + 1; w++)            // fill bucket 0x5a, then drop
      push_req(REQ_LEARN, addr_in_bucket(8'h5a), 4'(w + 8));
    push_req(REQ_TICK, '1, 4'hF);
    push_cfg(16'd1);                            // timeout of one
    push_req(REQ_TICK, '0, '0);
    push_req(REQ_LOOKUP, '0, '0);
    push_cfg(16'd0);                            // zero: every tick clears all
    push_req(REQ_LEARN, 48'h0123_4567_89ab, 4'h3);
    push_req(REQ_TICK, '0, '0);
    push_cfg(16'hFFFF);                         // largest timeout
    push_req(REQ_LEARN, 48'hAAAA_5555_AAAA, 4'hA);
    push_req(REQ_LEARN, 48'h5555_AAAA_5555, 4'h5);
    push_req(REQ_TICK, '0, '0);

    random_phase(500, 6);
    push_cfg(16'd3);
    random_phase(500, 10);
    push_cfg(TimeoutReset);
    random_phase(350, 4);
    push_cfg(16'd2);
    random_phase(250, 12);

    wait (rst_ni);
    wait (pending_ops.size() < 120);
    quiet_tail = 1;
    wait (pending_ops.size() == 0 && expected_res.size() == 0);
    repeat (NE + 50) @(posedge clk_i);
    if (err_count == 0 && expected_res.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

endmodule
